@@ rtl/anbs_pkg.sv @@
// types and constants shared by the annex b nal splitter modules
// no dependencies
package anbs_pkg;

    localparam int MaxResults = 5;
    localparam int BufDepth   = MaxResults + 1;
    localparam int CountW     = $clog2(BufDepth + 1);
    localparam int BatchW     = $clog2(MaxResults + 1);

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic       first_of_nal;
        logic [4:0] nal_type;
        logic       last_result;
    } t_result;

    typedef struct packed {
        logic [BatchW-1:0]             count;
        t_result [MaxResults-1:0]      entry;
    } t_batch;

endpackage

@@ rtl/anbs_parse.sv @@
// start code search and nal state: turns one accepted byte into a batch of results
// depends on anbs_pkg
module anbs_parse
    import anbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_stream_byte,
    input  logic       i_end_of_buffer,
    output t_batch     o_batch
);

    logic [1:0] r_zero_run, n_zero_run;
    logic       r_inside_nal, n_inside_nal;
    logic       r_expect_first, n_expect_first;
    logic [4:0] r_current_type, n_current_type;

    logic       is_zero;
    logic       is_start;
    logic [2:0] nz;
    logic       has_b;
    logic       mark_a;
    logic       mark_b;
    logic [2:0] npay;
    logic       took;
    logic [4:0] new_type;
    logic [2:0] cnt;

    assign is_zero  = (i_stream_byte == BYTE_ZERO);
    assign is_start = (i_stream_byte == BYTE_ONE) && (r_zero_run >= 2'd2);

    always_comb begin
        nz     = '0;
        has_b  = 1'b0;
        mark_a = 1'b0;
        unique if (is_zero) begin
            // a fourth zero pushes the oldest held one out; buffer end flushes the rest
            if (r_inside_nal) begin
                nz = ((r_zero_run == 2'd3) ? 3'd1 : 3'd0)
                   + (i_end_of_buffer ?
                      ((r_zero_run == 2'd3) ? 3'd3 : ({1'b0, r_zero_run} + 3'd1)) : 3'd0);
            end
        end else if (is_start) begin
            mark_a = r_inside_nal && !r_expect_first;
        end else begin
            if (r_inside_nal) begin
                nz    = {1'b0, r_zero_run};
                has_b = 1'b1;
            end
        end
    end

    assign npay     = nz + {2'b00, has_b};
    assign took     = (npay != 3'd0);
    assign new_type = (r_expect_first && took) ?
                      ((nz != 3'd0) ? 5'd0 : i_stream_byte[4:0]) : r_current_type;
    // a start code on the last byte opens an empty unit that closes silently
    assign mark_b = i_end_of_buffer && !is_start && r_inside_nal
                    && (!r_expect_first || took);
    assign cnt    = npay + {2'b00, (mark_a || mark_b)};

    always_comb begin
        o_batch.count = cnt;
        for (int i = 0; i < MaxResults; i++) begin
            o_batch.entry[i].nal_type    = new_type;
            o_batch.entry[i].first_of_nal = (i == 0) && r_expect_first && took;
            o_batch.entry[i].last_result = (3'(i) == (cnt - 3'd1));
            if (3'(i) < nz) begin
                o_batch.entry[i].kind         = KIND_PAYLOAD;
                o_batch.entry[i].payload_byte = BYTE_ZERO;
            end else if ((3'(i) == nz) && has_b) begin
                o_batch.entry[i].kind         = KIND_PAYLOAD;
                o_batch.entry[i].payload_byte = i_stream_byte;
            end else begin
                o_batch.entry[i].kind         = KIND_END;
                o_batch.entry[i].payload_byte = BYTE_ZERO;
            end
        end
    end

    always_comb begin
        n_zero_run     = r_zero_run;
        n_inside_nal   = r_inside_nal;
        n_expect_first = r_expect_first && !took;
        n_current_type = new_type;
        priority if (i_end_of_buffer) begin
            n_zero_run     = 2'd0;
            n_inside_nal   = 1'b0;
            n_expect_first = 1'b0;
        end else if (is_zero) begin
            if (r_zero_run != 2'd3) begin
                n_zero_run = r_zero_run + 2'd1;
            end
        end else if (is_start) begin
            n_zero_run     = 2'd0;
            n_inside_nal   = 1'b1;
            n_expect_first = 1'b1;
        end else begin
            n_zero_run = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run     <= 2'd0;
            r_inside_nal   <= 1'b0;
            r_expect_first <= 1'b0;
            r_current_type <= 5'd0;
        end else if (i_accept) begin
            r_zero_run     <= n_zero_run;
            r_inside_nal   <= n_inside_nal;
            r_expect_first <= n_expect_first;
            r_current_type <= n_current_type;
        end
    end

    a_first_needs_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_expect_first |-> r_inside_nal)
        else $error("expect_first set outside a nal unit");

endmodule

@@ rtl/anbs_outq.sv @@
// output queue: holds the results of a byte and hands them out one beat at a time
// depends on anbs_pkg
module anbs_outq
    import anbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_batch  i_batch,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_result,
    output logic    o_room
);

    t_result [BufDepth-1:0] r_buf, n_buf;
    logic [CountW-1:0]      r_count, n_count;
    logic                   pop;
    logic [CountW-1:0]      base;
    logic [CountW-1:0]      fill;
    logic [CountW-1:0]      idx;

    assign o_valid  = (r_count != '0);
    assign o_result = r_buf[0];
    assign o_room   = (r_count <= CountW'(1));
    assign pop      = o_valid && !i_stall;
    assign base     = r_count - CountW'(pop);
    assign fill     = i_push ? CountW'(i_batch.count) : '0;
    assign n_count  = base + fill;

    always_comb begin
        n_buf = r_buf;
        idx   = '0;
        for (int j = 0; j < BufDepth; j++) begin
            if (pop && (j < BufDepth - 1)) begin
                n_buf[j] = r_buf[j + 1];
            end
            // append the new batch right behind whatever survives the pop
            idx = CountW'(j) - base;
            if ((CountW'(j) >= base) && (idx < fill)) begin
                n_buf[j] = i_batch.entry[idx[BatchW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(BufDepth))
        else $error("output queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_room)
        else $error("batch pushed without room");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_push && !pop) |=> $stable(r_count))
        else $error("queue count moved without push or pop");

endmodule

@@ rtl/annexb_nal_splitter_unit.sv @@
// H.264 annex b start code splitter, one stream byte per beat in, one result per beat out.
// A byte is taken in the cycle it arrives unless o_stall is high; its zero to five
// results land in a six-entry output queue and leave one per cycle while i_stall is low,
// so a plain payload stream runs at one byte per cycle. A byte that yields several results
// keeps the output busy with them in turn, and the input stalls while more than one result
// is still queued. Bytes before the first start code are dropped, held zeros are flushed
// at end of buffer, and every end of buffer closes the open nal unit.
// depends on anbs_pkg, anbs_parse, anbs_outq
module annexb_nal_splitter_unit
    import anbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_stream_byte,
    input  logic       i_end_of_buffer,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_kind,
    output logic [7:0] o_payload_byte,
    output logic       o_first_of_nal,
    output logic [4:0] o_nal_type,
    output logic       o_last_result
);

    logic    accept;
    logic    room;
    t_batch  batch;
    t_result head;

    assign o_stall = !room;
    assign accept  = i_valid && room;

    anbs_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_stream_byte  (i_stream_byte),
        .i_end_of_buffer(i_end_of_buffer),
        .o_batch        (batch)
    );

    anbs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_batch (batch),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_result(head),
        .o_room  (room)
    );

    assign o_kind         = head.kind;
    assign o_payload_byte = head.payload_byte;
    assign o_first_of_nal = head.first_of_nal;
    assign o_nal_type     = head.nal_type;
    assign o_last_result  = head.last_result;

endmodule
